/* rtl/core/longest_increasing_subsequence_unit_macros.svh */
// Assertion macros for the longest increasing subsequence unit.
// Included by files that carry concurrent assertions; depends on nothing else.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_UNIT_MACROS_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LISU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lisu: same-cycle check failed");
`define LISU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lisu: next-cycle check failed");
`else
`define LISU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LISU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/lisu_pkg.sv */
// Shared constants and types of the longest increasing subsequence unit.
// Depends on nothing; used by the controller and the top level.
`default_nettype none
package lisu_pkg;
    localparam int LISU_DEPTH      = 1024;
    localparam int LISU_VALUE_BITS = 32;
    localparam int RUN_W           = 11;
    localparam int OUT_TDATA_W     = 16;

    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic             store_full;
        logic             final_flag;
    } lisu_result_t;
endpackage
`default_nettype wire

/* rtl/core/lisu_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the tails store; depends on nothing.
`default_nettype none
module lisu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/lisu_ctrl.sv */
// Sequencer of the unit: top-tail check, binary search over the tails RAM, write-back.
// Depends on lisu_pkg; drives the ports of one lisu_ram instance.
`default_nettype none
module lisu_ctrl #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [VALUE_BITS-1:0]        in_value,
    input  wire logic                         in_last,
    input  wire logic                         out_free,
    output logic                              res_valid,
    output lisu_pkg::lisu_result_t            result,
    output logic                              mem_we,
    output logic      [$clog2(DEPTH)-1:0]     mem_waddr,
    output logic      [VALUE_BITS-1:0]        mem_wdata,
    output logic      [$clog2(DEPTH)-1:0]     mem_raddr,
    input  wire logic [VALUE_BITS-1:0]        mem_rdata
);
    import lisu_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_TOP, ST_SRCH, ST_OUT} state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   value_reg, value_next;
    logic                    last_reg, last_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic [AW-1:0]           lo_reg, lo_next;
    logic [AW-1:0]           hi_reg, hi_next;
    logic [AW-1:0]           mid_reg, mid_next;
    logic [CNT_W-1:0]        cnt_dec;
    logic [AW:0]             mid_sum;
    logic                    rd_less;
    logic                    val_above;

    assign cnt_dec   = count_reg - CNT_W'(1);
    assign rd_less   = $signed(mem_rdata) < $signed(value_reg);
    assign val_above = $signed(value_reg) > $signed(mem_rdata);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT) && out_free;
    assign result.run_length = RUN_W'(count_reg);
    assign result.store_full = ovf_reg;
    assign result.final_flag = last_reg;

    always_comb
    begin
        state_next = state_reg;
        value_next = value_reg;
        last_next  = last_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = value_reg;
        mem_raddr  = cnt_dec[AW-1:0];
        mid_sum    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = in_value;
                    last_next  = in_last;
                    if (count_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = in_value;
                        count_next = CNT_W'(1);
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_TOP;
                    end
                end
            end
            ST_TOP:
            begin
                if (val_above)
                begin
                    if (count_reg < CNT_W'(DEPTH))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_OUT;
                end
                else if (cnt_dec == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = cnt_dec[AW-1:0];
                    mid_sum    = {1'b0, cnt_dec[AW-1:0]};
                    mid_next   = mid_sum[AW:1];
                    mem_raddr  = mid_next;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (rd_less)
                begin
                    lo_next = mid_reg + AW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                if (lo_next == hi_next)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = lo_next;
                    state_next = ST_OUT;
                end
                else
                begin
                    mid_sum   = {1'b0, lo_next} + {1'b0, hi_next};
                    mid_next  = mid_sum[AW:1];
                    mem_raddr = mid_next;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    if (last_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            value_reg <= '0;
            last_reg  <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            mid_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            value_reg <= value_next;
            last_reg  <= last_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/longest_increasing_subsequence_unit.sv */
// Top level of the longest increasing subsequence unit: stream ports, result register.
// Depends on lisu_pkg, lisu_ctrl, lisu_ram and the assertion macro header.
//
// Channel   Direction  Signals                          Payload
// s_*       in         s_tvalid s_tready s_tdata s_tlast  value; last_item on s_tlast
// m_*       out        m_tvalid m_tready m_tdata m_tlast  run_length, store_full; final_flag
//
// A request goes straight to the output stage when the store is empty; otherwise
// it passes the top-tail check and, where needed, a binary search over the tails RAM.
// The search is bound by the registered read of the single tails RAM read port.
// Reset clears the length and the overflow flag; the RAM needs no clearing pass.
// A new request is taken while the previous result still waits in the output register;
// the request after it holds its result back until that register drains.
`default_nettype none
module longest_increasing_subsequence_unit #(
    parameter int DEPTH      = lisu_pkg::LISU_DEPTH,
    parameter int VALUE_BITS = lisu_pkg::LISU_VALUE_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // Fields from bit 0: value (VALUE_BITS, signed), zero pad to whole bytes.
    input  wire logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // Fields from bit 0: run_length (11), store_full (1), zero pad (4).
    output logic      [lisu_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                       m_tlast
);
    import lisu_pkg::*;

    `include "longest_increasing_subsequence_unit_macros.svh"

    localparam int AW = $clog2(DEPTH);

    logic                  out_free;
    logic                  res_valid;
    lisu_result_t          result;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;
    logic                  m_valid_reg;
    lisu_result_t          m_res_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({m_res_reg.store_full, m_res_reg.run_length});
    assign m_tlast  = m_res_reg.final_flag;

    lisu_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_BITS-1:0]),
        .in_last   (s_tlast),
        .out_free  (out_free),
        .res_valid (res_valid),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    lisu_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_tails (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_res_reg   <= '0;
        end
        else if (res_valid)
        begin
            m_valid_reg <= 1'b1;
            m_res_reg   <= result;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // A result is only handed over when the output register can take it.
    `LISU_ASSERT_IMP(a_res_slot_free, clk, rst_n, res_valid, (!m_valid_reg || m_tready))
    // An accepted request keeps the input closed in the next cycle.
    `LISU_ASSERT_NXT(a_busy_after_req, clk, rst_n, (s_tvalid && s_tready), !s_tready)
    // A dropped append only happens with the store saturated.
    `LISU_ASSERT_IMP(a_full_saturated, clk, rst_n, (res_valid && result.store_full), (result.run_length == RUN_W'(DEPTH)))
endmodule
`default_nettype wire
